>>> hw/rtl/tlk_pkg.sv
// shared types and constants for the timestamp lru key table
package tlk_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned TICK_W       = 32;

  localparam logic [CFG_W-1:0]  CAP_RESET    = 7'd64;
  localparam logic [TICK_W-1:0] TICK_NONE    = 32'hFFFF_FFFF;
  localparam logic [KEY_W-1:0]  KEY_ONES     = 32'hFFFF_FFFF;
  localparam logic [KEY_W-1:0]  EMPTY_OLDEST = 32'h000F_FFFF;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ENTER  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_DECIDE,
    ST_MIN,
    ST_TAKE_MIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic decide;
    logic start_min;
    logic take_min;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic need_min;
    logic out_busy;
  } sts_t;

endpackage

>>> hw/rtl/tlk_if.sv
// input and result channel interfaces
interface tlk_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] key;
  logic [31:0] tick;

  modport source (output valid, output operation, output key, output tick, input ready);
  modport sink (input valid, input operation, input key, input tick, output ready);
endinterface

interface tlk_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic        found;
  logic [31:0] stored_tick;

  modport source (output valid, output success, output found, output stored_tick, input ready);
  modport sink (input valid, input success, input found, input stored_tick, output ready);
endinterface

>>> hw/rtl/timestamp_lru_key_table.sv
// A bounded table of up to CAPACITY (key, tick) pairs with oldest-tick eviction. Each beat
// is handled alone: it is accepted, then the key scan reads one slot per cycle through the
// single read port of the slot memories and compares each registered read, then the
// table is updated. When the oldest key must be found again (table just became full, oldest
// key refreshed, or an eviction attempt) a second scan over all slots follows and the oldest
// key is taken from it. The result then moves into the output register once the previous
// result has left it; the next beat is accepted while a result still waits in the output
// register.
module timestamp_lru_key_table #(
  parameter int unsigned CAPACITY = tlk_pkg::DEF_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tlk_pkg::CFG_W-1:0] cfg_wdata_i,
  tlk_in_if.sink                    in_i,
  tlk_out_if.source                 out_o
);
  import tlk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlk_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_op_i           (in_i.operation),
    .in_key_i          (in_i.key),
    .in_tick_i         (in_i.tick),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_success_o     (out_o.success),
    .out_found_o       (out_o.found),
    .out_stored_tick_o (out_o.stored_tick)
  );

endmodule

>>> hw/rtl/tlk_ctrl.sv
// sequencer for lookup, update and oldest-tick search
module tlk_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  tlk_pkg::sts_t sts_i,
  output tlk_pkg::cmd_t cmd_o
);
  import tlk_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FIND;
      end
      ST_FIND: begin
        if (sts_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = sts_i.need_min ? ST_MIN : ST_DONE;
      end
      ST_MIN: begin
        if (sts_i.scan_done) state_d = ST_TAKE_MIN;
      end
      ST_TAKE_MIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q) inside
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECIDE: begin
        cmd_o.decide    = 1'b1;
        cmd_o.start_min = sts_i.need_min;
      end
      ST_TAKE_MIN: begin
        cmd_o.take_min = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = !sts_i.out_busy;
      end
      ST_FIND, ST_MIN: begin
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_FIND)
    else $error("accepted beat did not start a key scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_min |=> state_q == ST_MIN)
    else $error("minimum search started outside its state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == ST_IDLE)
    else $error("result loaded without returning to idle");

endmodule

>>> hw/rtl/tlk_dp.sv
// slot memories, valid bits, scan engine and result register
module tlk_dp #(
  parameter int unsigned CAPACITY = tlk_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlk_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  tlk_pkg::cmd_t               cmd_i,
  output tlk_pkg::sts_t               sts_o,
  input  logic                        in_op_i,
  input  logic [tlk_pkg::KEY_W-1:0]   in_key_i,
  input  logic [tlk_pkg::TICK_W-1:0]  in_tick_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_success_o,
  output logic                        out_found_o,
  output logic [tlk_pkg::TICK_W-1:0]  out_stored_tick_o
);
  import tlk_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW > CFG_W) ? CW : CFG_W;

  // slot storage
  logic [KEY_W-1:0]  key_mem  [CAPACITY];
  logic [TICK_W-1:0] tick_mem [CAPACITY];
  logic [CAPACITY-1:0] valid_q;

  logic [CFG_W-1:0]  cap_q;
  logic [CW-1:0]     count_q;
  logic [KEY_W-1:0]  oldest_q;

  // latched beat
  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [TICK_W-1:0] tick_q;

  // scan engine
  logic              scan_q;
  logic              mode_min_q;
  logic [AW-1:0]     cnt_q;
  logic              rd_vld_q;
  logic              rd_vbit_q;
  logic [AW-1:0]     rd_idx_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [TICK_W-1:0] rd_tick_q;

  // scan results
  logic              hit_q, vic_q, free_q;
  logic [AW-1:0]     hit_idx_q, vic_idx_q, free_idx_q;
  logic [TICK_W-1:0] hit_tick_q;
  logic [TICK_W-1:0] best_tick_q;
  logic [KEY_W-1:0]  best_key_q;

  // pending and output result
  logic              res_ok_q, res_found_q;
  logic [TICK_W-1:0] res_tick_q;
  logic              out_valid_q, out_success_q, out_found_q;
  logic [TICK_W-1:0] out_tick_q;

  // update decision
  logic [EW-1:0]     cap_ext, cap_lim, cap_eff, count_ext;
  logic              full;
  logic              mem_we, set_en, clr_en, cnt_inc, ok, need_min;
  logic [AW-1:0]     wa;
  logic [CAPACITY-1:0] valid_d;

  assign cap_ext   = EW'(cap_q);
  assign cap_lim   = EW'(CAPACITY);
  assign cap_eff   = (cap_ext > cap_lim) ? cap_lim : cap_ext;
  assign count_ext = EW'(count_q);
  assign full      = count_ext >= cap_eff;

  always_comb begin
    mem_we   = 1'b0;
    set_en   = 1'b0;
    clr_en   = 1'b0;
    cnt_inc  = 1'b0;
    ok       = 1'b1;
    need_min = 1'b0;
    wa       = hit_idx_q;
    if (op_q == OP_ENTER) begin
      if (hit_q) begin
        mem_we   = 1'b1;
        wa       = hit_idx_q;
        need_min = full && (key_q == oldest_q);
      end else if (!full) begin
        if (free_q) begin
          mem_we   = 1'b1;
          wa       = free_idx_q;
          set_en   = 1'b1;
          cnt_inc  = 1'b1;
          need_min = (count_ext + EW'(1)) == cap_eff;
        end else begin
          ok = 1'b0;
        end
      end else begin
        need_min = 1'b1;
        if (vic_q) begin
          clr_en = 1'b1;
          mem_we = 1'b1;
          set_en = 1'b1;
          wa     = (free_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
        end else begin
          ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (clr_en) valid_d[vic_idx_q] = 1'b0;
    if (set_en) valid_d[wa] = 1'b1;
  end

  assign sts_o.scan_done = !scan_q && !rd_vld_q;
  assign sts_o.need_min  = need_min;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && mem_we) begin
      key_mem[wa]  <= key_q;
      tick_mem[wa] <= tick_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_q) begin
      rd_key_q  <= key_mem[cnt_q];
      rd_tick_q <= tick_mem[cnt_q];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      oldest_q    <= '0;
      valid_q     <= '0;
      scan_q      <= 1'b0;
      mode_min_q  <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.decide) begin
        valid_q <= valid_d;
        if (cnt_inc) count_q <= count_q + CW'(1);
      end
      if (cmd_i.take_min) begin
        oldest_q <= (best_key_q == KEY_ONES) ? '0 : best_key_q;
      end
      rd_vld_q <= scan_q;
      if (cmd_i.accept || cmd_i.start_min) begin
        scan_q     <= 1'b1;
        cnt_q      <= '0;
        mode_min_q <= cmd_i.start_min;
      end else if (scan_q) begin
        if (cnt_q == AW'(CAPACITY - 1)) begin
          scan_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + AW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (scan_q) begin
      rd_vbit_q <= valid_q[cnt_q];
      rd_idx_q  <= cnt_q;
    end
    if (cmd_i.accept) begin
      op_q   <= in_op_i;
      key_q  <= in_key_i;
      tick_q <= in_tick_i;
      hit_q  <= 1'b0;
      vic_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_vld_q && !mode_min_q) begin
      if (rd_vbit_q && !hit_q && (rd_key_q == key_q)) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= rd_idx_q;
        hit_tick_q <= rd_tick_q;
      end
      if (rd_vbit_q && !vic_q && (rd_key_q == oldest_q)) begin
        vic_q     <= 1'b1;
        vic_idx_q <= rd_idx_q;
      end
      if (!rd_vbit_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.start_min) begin
      best_tick_q <= TICK_NONE;
      best_key_q  <= EMPTY_OLDEST;
    end else if (rd_vld_q && mode_min_q && rd_vbit_q && (rd_tick_q < best_tick_q)) begin
      best_tick_q <= rd_tick_q;
      best_key_q  <= rd_key_q;
    end
    if (cmd_i.decide) begin
      res_ok_q    <= ok;
      res_found_q <= hit_q;
      res_tick_q  <= ((op_q == OP_LOOKUP) && hit_q) ? hit_tick_q : '0;
    end
    if (cmd_i.load_out) begin
      out_success_q <= res_ok_q;
      out_found_q   <= res_found_q;
      out_tick_q    <= res_tick_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_success_o     = out_success_q;
  assign out_found_o       = out_found_q;
  assign out_stored_tick_o = out_tick_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("valid slots disagree with entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && mem_we) |-> !scan_q && !rd_vld_q)
    else $error("slot write during a scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && set_en) |-> !valid_q[wa] || (clr_en && wa == vic_idx_q))
    else $error("insert into an occupied slot");

endmodule

>>> tb/sv/timestamp_lru_key_table_check.sv
// shadow table for the timestamp lru key table: watches both channels, predicts and compares
`timescale 1ns / 1ps
module timestamp_lru_key_table_check #(
  parameter int unsigned CAPACITY = tlk_pkg::DEF_CAPACITY
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tlk_pkg::CFG_W-1:0] cfg_wdata_i,
  tlk_in_if                         in_i,
  tlk_out_if                        out_i,
  output int unsigned               fail_count_o,
  output int unsigned               awaiting_o
);
  import tlk_pkg::*;

  typedef struct packed {
    logic              success;
    logic              found;
    logic [TICK_W-1:0] stored_tick;
  } table_result_t;

  logic [KEY_W-1:0]  shadow_key  [CAPACITY];
  logic [TICK_W-1:0] shadow_tick [CAPACITY];
  logic              shadow_used [CAPACITY];
  int unsigned       shadow_count;
  logic [KEY_W-1:0]  shadow_oldest;
  logic [CFG_W-1:0]  shadow_cap;
  table_result_t     result_q [$];
  int unsigned       failures;

  function automatic int slot_of(logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      if (shadow_used[i] && shadow_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic int open_slot();
    int i;
    for (i = 0; i < CAPACITY; i++) begin
      if (!shadow_used[i]) return i;
    end
    return -1;
  endfunction

  // lowest tick wins, ties to the lowest slot, all-ones ticks never chosen
  function automatic logic [KEY_W-1:0] oldest_owner();
    logic [TICK_W-1:0] best;
    logic [KEY_W-1:0]  owner;
    int                i;
    best  = TICK_NONE;
    owner = EMPTY_OLDEST;
    for (i = 0; i < CAPACITY; i++) begin
      if (shadow_used[i] && shadow_tick[i] < best) begin
        best  = shadow_tick[i];
        owner = shadow_key[i];
      end
    end
    return (owner == KEY_ONES) ? '0 : owner;
  endfunction

  function automatic void place(int slot, logic [KEY_W-1:0] k, logic [TICK_W-1:0] t);
    shadow_key[slot]  = k;
    shadow_tick[slot] = t;
    shadow_used[slot] = 1'b1;
  endfunction

  function automatic table_result_t apply_beat(logic op, logic [KEY_W-1:0] k,
                                               logic [TICK_W-1:0] t);
    table_result_t r;
    int unsigned   lim;
    int            hit;
    int            slot;
    int            victim;
    lim           = (shadow_cap > CAPACITY) ? CAPACITY : shadow_cap;
    hit           = slot_of(k);
    r.success     = 1'b1;
    r.found       = (hit >= 0);
    r.stored_tick = '0;
    if (op == OP_LOOKUP) begin
      if (hit >= 0) r.stored_tick = shadow_tick[hit];
    end else if (hit >= 0) begin
      shadow_tick[hit] = t;
      if (shadow_count >= lim && k == shadow_oldest) shadow_oldest = oldest_owner();
    end else if (shadow_count < lim) begin
      slot = open_slot();
      if (slot < 0) begin
        r.success = 1'b0;
      end else begin
        place(slot, k, t);
        shadow_count++;
        if (shadow_count == lim) shadow_oldest = oldest_owner();
      end
    end else begin
      victim = slot_of(shadow_oldest);
      if (victim >= 0) begin
        shadow_used[victim] = 1'b0;
        slot = open_slot();
        if (slot >= 0) place(slot, k, t);
        else r.success = 1'b0;
      end else begin
        r.success = 1'b0;
      end
      shadow_oldest = oldest_owner();
    end
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    failures++;
    if (failures <= 10)
      $display("%0t: %s expected %h got %h", $time, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    int            i;
    if (!rst_ni) begin
      for (i = 0; i < CAPACITY; i++) begin
        shadow_key[i]  = '0;
        shadow_tick[i] = '0;
        shadow_used[i] = 1'b0;
      end
      shadow_count  = 0;
      shadow_oldest = '0;
      shadow_cap    = CAP_RESET;
      failures      = 0;
      result_q.delete();
      fail_count_o <= 0;
      awaiting_o   <= 0;
    end else begin
      if (cfg_we_i) shadow_cap = cfg_wdata_i;
      if (in_i.valid && in_i.ready)
        result_q.push_back(apply_beat(in_i.operation, in_i.key, in_i.tick));
      if (out_i.valid && out_i.ready) begin
        if (result_q.size() == 0) begin
          flag("unrequested beat, stored_tick", '0, out_i.stored_tick);
        end else begin
          want = result_q.pop_front();
          if (out_i.success !== want.success)
            flag("success", 32'(want.success), 32'(out_i.success));
          if (out_i.found !== want.found)
            flag("found", 32'(want.found), 32'(out_i.found));
          if (out_i.stored_tick !== want.stored_tick)
            flag("stored_tick", want.stored_tick, out_i.stored_tick);
        end
      end
      awaiting_o   <= result_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

>>> tb/sv/timestamp_lru_key_table_test.sv
// test top for the timestamp lru key table: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps
module timestamp_lru_key_table_test;
  import tlk_pkg::*;

  localparam int unsigned CAPACITY    = DEF_CAPACITY;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned KEY_POOL    = 96;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_BEATS = 163;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      fail_count;
  int unsigned      awaiting;
  int unsigned      cycles = 0;
  int               in_calm;
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [TICK_W-1:0] now_tick;
  logic [CFG_W-1:0] phase_cap [PHASES] = '{7'd3, 7'd1, 7'd0, 7'd2, 7'd5, 7'd16, 7'd127,
                                           7'd64, 7'd7, 7'd4};

  tlk_in_if  in_ch ();
  tlk_out_if out_ch ();

  timestamp_lru_key_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  timestamp_lru_key_table_check #(
    .CAPACITY(CAPACITY)
  ) u_table_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .fail_count_o(fail_count),
    .awaiting_o  (awaiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timestamp_lru_key_table_test: errors");
      $finish;
    end
  end

  // mostly short gaps, some long ones, and stretches with none
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    if (roll < 75) return $urandom_range(0, 2);
    if (roll < 94) return $urandom_range(3, 9);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_beat(input logic op, input logic [KEY_W-1:0] k,
                           input logic [TICK_W-1:0] t);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= k;
    in_ch.tick      <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] cap);
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_beat(input int unsigned span, input int unsigned base);
    logic              op;
    logic [KEY_W-1:0]  k;
    logic [TICK_W-1:0] t;
    int                roll;
    op   = ($urandom_range(0, 99) < 30) ? OP_LOOKUP : OP_ENTER;
    roll = $urandom_range(0, 99);
    if (roll < 88) k = key_pool[(base + $urandom_range(0, span - 1)) % KEY_POOL];
    else k = $urandom;
    now_tick = now_tick + $urandom_range(1, 4);
    roll = $urandom_range(0, 99);
    if (roll < 70) t = now_tick;
    else if (roll < 80) t = now_tick - $urandom_range(1, 64);
    else if (roll < 88) t = $urandom;
    else if (roll < 94) t = TICK_NONE;
    else t = '0;
    send_beat(op, k, t);
  endtask

  initial begin : result_sink
    int stall;
    int calm;
    calm         = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = pick_gap(calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : beat_source
    int unsigned ph;
    int unsigned n;
    int unsigned span;
    int unsigned base;
    int unsigned fill;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_LOOKUP;
    in_ch.key       = '0;
    in_ch.tick      = '0;
    in_calm         = 0;
    now_tick        = 32'h0000_0100;
    for (n = 0; n < KEY_POOL; n++) key_pool[n] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = EMPTY_OLDEST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, extremes of key and tick
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_ENTER, KEY_ONES, TICK_NONE);
    send_beat(OP_LOOKUP, KEY_ONES, TICK_NONE);
    send_beat(OP_ENTER, '0, '0);
    send_beat(OP_ENTER, '0, 32'd5);
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_ENTER, EMPTY_OLDEST, 32'd7);
    send_beat(OP_ENTER, 32'h5555_AAAA, 32'hAAAA_5555);
    send_beat(OP_LOOKUP, 32'hAAAA_5555, '0);
    send_beat(OP_LOOKUP, 32'h5555_AAAA, '0);
    drain();
    // zero capacity: stale oldest key evicted, all-ones key as oldest, failed evictions
    set_capacity(7'd0);
    send_beat(OP_ENTER, 32'h0000_1000, 32'd9);
    send_beat(OP_LOOKUP, '0, '0);
    send_beat(OP_ENTER, KEY_ONES, 32'd1);
    send_beat(OP_ENTER, 32'h0000_2000, 32'd20);
    send_beat(OP_ENTER, 32'h0000_3000, 32'd21);
    send_beat(OP_ENTER, 32'h0000_3000, 32'd22);
    // no tick left below all ones
    send_beat(OP_ENTER, KEY_ONES, TICK_NONE);
    send_beat(OP_ENTER, 32'h0000_1000, TICK_NONE);
    send_beat(OP_ENTER, 32'h5555_AAAA, TICK_NONE);
    send_beat(OP_ENTER, 32'h0000_2000, TICK_NONE);
    send_beat(OP_ENTER, 32'h0000_6000, 32'd23);
    send_beat(OP_LOOKUP, 32'h0000_2000, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      set_capacity(phase_cap[ph]);
      fill = (phase_cap[ph] > CAPACITY) ? CAPACITY : phase_cap[ph];
      span = fill * 3 / 2 + 4;
      if (span > KEY_POOL) span = KEY_POOL;
      base = $urandom_range(0, KEY_POOL - 1);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 59) == 0) drain();
        random_beat(span, base);
      end
    end

    drain();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && awaiting == 0)
      $display("timestamp_lru_key_table_test: clean");
    else
      $display("timestamp_lru_key_table_test: errors");
    $finish;
  end

endmodule
